@@ design/dfpf_pkg.sv @@
// Shared types and constants for the distance frame parser and jump filter.
// No dependencies; used by every module in the design folder.
package dfpf_pkg;

   localparam int WINDOW_BYTES_DEF = 16;

   localparam int BYTE_W  = 8;
   localparam int MM_W    = 16;
   localparam int CM_W    = 13;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [BYTE_W-1:0] START_BYTE = 8'hFF;

   localparam logic [MM_W-1:0] MIN_DIST_RESET   = 16'd280;
   localparam logic [CM_W-1:0] JUMP_LIMIT_RESET = 13'd15;

   // Divide by ten: floor(x * 52429 / 2^19) is exact for any 16-bit x
   localparam logic [MM_W-1:0] DIV10_MULT  = 16'd52429;
   localparam int              DIV10_SHIFT = 19;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_DIST   = 1'd0,
      CSR_JUMP_LIMIT = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_ACCEPT = 2'd0,
      ST_CSUM   = 2'd1,
      ST_CLOSE  = 2'd2,
      ST_HOLD   = 2'd3
   } status_type;

   // Frame verdict before the jump filter; ST_ACCEPT here means "valid reading"
   typedef struct packed {
      status_type      status;
      logic [CM_W-1:0] cm;
   } verdict_type;

endpackage

@@ design/dfpf_frame.sv @@
// Byte input register, window/frame parser, checksum and range check.
// Depends on dfpf_pkg; feeds one verdict beat per completed frame to dfpf_filter.
module dfpf_frame #(
   parameter int WINDOW_BYTES = dfpf_pkg::WINDOW_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [dfpf_pkg::BYTE_W-1:0]  req_rx_byte,
   input  logic [dfpf_pkg::MM_W-1:0]    min_distance_mm,
   output logic                         vrd_valid,
   input  logic                         vrd_ready,
   output dfpf_pkg::verdict_type        vrd
);

   localparam int FILL_W = $clog2(WINDOW_BYTES + 1);

   logic [dfpf_pkg::BYTE_W-1:0] byte_ff;
   logic                        byte_valid_ff, byte_valid_in;
   logic [FILL_W-1:0]           fill_ff, fill_in, fill_inc;
   logic                        start_ff, start_in;
   logic [1:0]                  after_ff, after_in;
   logic [dfpf_pkg::BYTE_W-1:0] high_ff, high_in, low_ff, low_in;
   logic                        vrd_valid_ff, vrd_valid_in;
   dfpf_pkg::verdict_type       vrd_ff, vrd_in;

   logic                        s2_free, take, frame_done;
   logic [dfpf_pkg::BYTE_W-1:0] csum;
   logic [dfpf_pkg::MM_W-1:0]   mm;
   logic [2*dfpf_pkg::MM_W-1:0] product;

   assign s2_free   = !vrd_valid_ff || vrd_ready;
   assign take      = byte_valid_ff && s2_free;
   assign req_ready = !byte_valid_ff || s2_free;

   assign byte_valid_in = (req_valid && req_ready) ? 1'b1 :
                          take                     ? 1'b0 : byte_valid_ff;

   assign fill_inc = fill_ff + FILL_W'(1);

   always_comb begin
      start_in   = start_ff;
      after_in   = after_ff;
      high_in    = high_ff;
      low_in     = low_ff;
      fill_in    = fill_ff;
      frame_done = 1'b0;
      if (take) begin
         fill_in = fill_inc;
         if (start_ff) begin
            case (after_ff)
               2'd0: begin
                  high_in  = byte_ff;
                  after_in = 2'd1;
               end
               2'd1: begin
                  low_in   = byte_ff;
                  after_in = 2'd2;
               end
               default: begin
                  frame_done = 1'b1;
               end
            endcase
         end else if (byte_ff == dfpf_pkg::START_BYTE) begin
            start_in = 1'b1;
            after_in = 2'd0;
         end
         // Drop the window on a finished frame or when it fills up
         if (frame_done || (fill_inc >= FILL_W'(WINDOW_BYTES))) begin
            fill_in  = '0;
            start_in = 1'b0;
            after_in = 2'd0;
         end
      end
   end

   // Checksum byte is byte_ff; high and low are already held
   assign csum    = dfpf_pkg::BYTE_W'(dfpf_pkg::START_BYTE + high_ff + low_ff);
   assign mm      = {high_ff, low_ff};
   assign product = mm * dfpf_pkg::DIV10_MULT;

   always_comb begin
      vrd_in.cm = product[dfpf_pkg::DIV10_SHIFT +: dfpf_pkg::CM_W];
      if (csum != byte_ff) begin
         vrd_in.status = dfpf_pkg::ST_CSUM;
      end else if (mm <= min_distance_mm) begin
         vrd_in.status = dfpf_pkg::ST_CLOSE;
      end else begin
         vrd_in.status = dfpf_pkg::ST_ACCEPT;
      end
   end

   assign vrd_valid_in = (take && frame_done) ? 1'b1 :
                         vrd_ready            ? 1'b0 : vrd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         fill_ff       <= '0;
         start_ff      <= 1'b0;
         after_ff      <= 2'd0;
         vrd_valid_ff  <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         fill_ff       <= fill_in;
         start_ff      <= start_in;
         after_ff      <= after_in;
         vrd_valid_ff  <= vrd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
      high_ff <= high_in;
      low_ff  <= low_in;
      if (take && frame_done) begin
         vrd_ff <= vrd_in;
      end
   end

   assign vrd_valid = vrd_valid_ff;
   assign vrd       = vrd_ff;

endmodule

@@ design/dfpf_filter.sv @@
// Jump filter state and result register.
// Depends on dfpf_pkg; takes verdict beats from dfpf_frame.
module dfpf_filter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         vrd_valid,
   output logic                         vrd_ready,
   input  dfpf_pkg::verdict_type        vrd,
   input  logic [dfpf_pkg::CM_W-1:0]    jump_limit_cm,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [dfpf_pkg::CM_W-1:0]    rsp_distance_out_cm,
   output logic [1:0]                   rsp_status
);

   logic [dfpf_pkg::CM_W-1:0] last_ff, last_in;
   logic                      hold_ff, hold_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [dfpf_pkg::CM_W-1:0] dist_ff, dist_in;
   dfpf_pkg::status_type      status_ff, status_in;
   logic [dfpf_pkg::CM_W-1:0] diff;
   logic                      move;

   assign vrd_ready = !rsp_valid_ff || rsp_ready;
   assign move      = vrd_valid && vrd_ready;

   assign diff = (vrd.cm >= last_ff) ? (vrd.cm - last_ff) : (last_ff - vrd.cm);

   always_comb begin
      last_in   = last_ff;
      hold_in   = hold_ff;
      dist_in   = '0;
      status_in = vrd.status;
      if (vrd.status == dfpf_pkg::ST_ACCEPT) begin
         if (!hold_ff && (diff >= jump_limit_cm)) begin
            // Hold this reading; the next valid one goes through
            hold_in   = 1'b1;
            status_in = dfpf_pkg::ST_HOLD;
         end else begin
            hold_in = 1'b0;
            last_in = vrd.cm;
            dist_in = vrd.cm;
         end
      end
   end

   assign rsp_valid_in = move      ? 1'b1 :
                         rsp_ready ? 1'b0 : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         hold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (move) begin
            last_ff <= last_in;
            hold_ff <= hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         dist_ff   <= dist_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_distance_out_cm = dist_ff;
   assign rsp_status          = status_ff;

endmodule

@@ design/distance_frame_parser_filter_top.sv @@
// Top level of the distance frame parser and jump filter: CSRs and the two stages.
// Depends on dfpf_pkg, dfpf_frame and dfpf_filter.
//
//   port group  direction  beat
//   req_*       in         one received serial byte (rx_byte)
//   rsp_*       out        one distance result per completed frame
//   csr_*       in         register write, index 0 min distance, 1 jump limit
//
// One byte is taken every cycle unless the input is stalled; a frame's checksum byte goes
// through the input register, then the verdict register, then the result register, where its result is valid.
// The filter state advances when a verdict moves into the result register.
// A stalled result stalls the verdict and then the input; each stage keeps a
// beat while the next is full. Reset is synchronous.
module distance_frame_parser_filter_top #(
   parameter int WINDOW_BYTES = dfpf_pkg::WINDOW_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [dfpf_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [dfpf_pkg::CM_W-1:0]       rsp_distance_out_cm,
   output logic [1:0]                      rsp_status,
   input  logic                            csr_write_enable,
   input  logic [dfpf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dfpf_pkg::CSR_W-1:0]      csr_write_data
);

   logic [dfpf_pkg::MM_W-1:0] min_dist_ff;
   logic [dfpf_pkg::CM_W-1:0] jump_limit_ff;
   logic                      vrd_valid, vrd_ready;
   dfpf_pkg::verdict_type     vrd;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff   <= dfpf_pkg::MIN_DIST_RESET;
         jump_limit_ff <= dfpf_pkg::JUMP_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (dfpf_pkg::csr_index_type'(csr_index))
            dfpf_pkg::CSR_MIN_DIST: begin
               min_dist_ff <= csr_write_data;
            end
            dfpf_pkg::CSR_JUMP_LIMIT: begin
               jump_limit_ff <= csr_write_data[dfpf_pkg::CM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   dfpf_frame #(
      .WINDOW_BYTES(WINDOW_BYTES)
   ) u_frame (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .min_distance_mm (min_dist_ff),
      .vrd_valid       (vrd_valid),
      .vrd_ready       (vrd_ready),
      .vrd             (vrd)
   );

   dfpf_filter u_filter (
      .clock               (clock),
      .reset               (reset),
      .vrd_valid           (vrd_valid),
      .vrd_ready           (vrd_ready),
      .vrd                 (vrd),
      .jump_limit_cm       (jump_limit_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_distance_out_cm (rsp_distance_out_cm),
      .rsp_status          (rsp_status)
   );

endmodule
